// ===== rtl/core/hs1_pkg.sv =====
// ----------------------------------------------------------------------------
// hs1_pkg
// Shared types and constants of the HMAC-SHA1 engine.
// ----------------------------------------------------------------------------
package hs1_pkg;

   localparam logic [159:0] SHA_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                      32'h10325476, 32'hC3D2E1F0};
   localparam logic [31:0] K_R0 = 32'h5A827999;
   localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3 = 32'hCA62C1D6;

   localparam logic [7:0] IPAD     = 8'h36;
   localparam logic [7:0] OPAD     = 8'h5C;
   localparam logic [7:0] PAD_LEAD = 8'h80;
   // byte position of the length field: 448 bits into the block
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [4:0] MAC_BYTES = 5'd20;

   // byte pushed into the hash core
   typedef struct packed {
      logic       start;
      logic       valid;
      logic [7:0] data;
   } push_type;

   typedef enum logic [3:0] {
      CS_IDLE  = 4'b0001,
      CS_LOAD  = 4'b0010,
      CS_ROUND = 4'b0100,
      CS_ADD   = 4'b1000
   } core_state_type;

   // byte idx of a 160-bit digest, big-endian
   function automatic logic [7:0] digest_byte(input logic [159:0] vec,
                                              input logic [4:0] idx);
      logic [159:0] sh;
      sh = vec >> (8 * (MAC_BYTES - 5'd1 - idx));
      return sh[7:0];
   endfunction

endpackage

// ===== rtl/core/hs1_core.sv =====
// ----------------------------------------------------------------------------
// hs1_core
// SHA-1 byte absorber: block buffer in a memory, one round per cycle.
// ----------------------------------------------------------------------------
module hs1_core (
   input  logic              clock,
   input  logic              reset,
   input  hs1_pkg::push_type push,
   output logic              busy,
   output logic [159:0]      chain,
   output logic [63:0]       bit_count
);

   logic [7:0]   blk_mem [64];
   logic [7:0]   rd_data_ff;
   logic         rd_vld_ff, rd_vld_in;
   logic [6:0]   addr_ff, addr_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic [511:0] wbuf_ff, wbuf_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [159:0] chain_ff, chain_in;
   logic [63:0]  bits_ff, bits_in;
   hs1_pkg::core_state_type state_ff, state_in;

   logic        accept;
   logic [5:0]  idx;
   logic [31:0] f, k, tmp, wnew;

   assign accept    = push.valid && (state_ff == hs1_pkg::CS_IDLE);
   assign idx       = bits_ff[8:3];
   assign busy      = (state_ff != hs1_pkg::CS_IDLE);
   assign chain     = chain_ff;
   assign bit_count = bits_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         blk_mem[idx] <= push.data;
      end
      if (state_ff == hs1_pkg::CS_LOAD && !addr_ff[6]) begin
         rd_data_ff <= blk_mem[addr_ff[5:0]];
      end
   end

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = hs1_pkg::K_R0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = hs1_pkg::K_R1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = hs1_pkg::K_R2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = hs1_pkg::K_R3;
      end
      tmp  = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + wbuf_ff[511:480];
      // w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
      wnew = wbuf_ff[95:64] ^ wbuf_ff[255:224] ^ wbuf_ff[447:416] ^ wbuf_ff[511:480];
      wnew = {wnew[30:0], wnew[31]};
   end

   always_comb begin
      state_in  = state_ff;
      bits_in   = bits_ff;
      chain_in  = chain_ff;
      addr_in   = addr_ff;
      rnd_in    = rnd_ff;
      wbuf_in   = wbuf_ff;
      rd_vld_in = 1'b0;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      unique case (state_ff)
         hs1_pkg::CS_IDLE: begin
            if (push.start) begin
               chain_in = hs1_pkg::SHA_IV;
               bits_in  = '0;
            end else if (accept) begin
               bits_in = bits_ff + 64'd8;
               if (idx == 6'd63) begin
                  addr_in  = '0;
                  state_in = hs1_pkg::CS_LOAD;
               end
            end
         end
         hs1_pkg::CS_LOAD: begin
            rd_vld_in = !addr_ff[6];
            if (!addr_ff[6]) begin
               addr_in = addr_ff + 7'd1;
            end
            if (rd_vld_ff) begin
               wbuf_in = {wbuf_ff[503:0], rd_data_ff};
            end
            if (addr_ff[6]) begin
               a_in = chain_ff[159:128];
               b_in = chain_ff[127:96];
               c_in = chain_ff[95:64];
               d_in = chain_ff[63:32];
               e_in = chain_ff[31:0];
               rnd_in   = '0;
               state_in = hs1_pkg::CS_ROUND;
            end
         end
         hs1_pkg::CS_ROUND: begin
            a_in    = tmp;
            b_in    = a_ff;
            c_in    = {b_ff[1:0], b_ff[31:2]};
            d_in    = c_ff;
            e_in    = d_ff;
            wbuf_in = {wbuf_ff[479:0], wnew};
            rnd_in  = rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) begin
               state_in = hs1_pkg::CS_ADD;
            end
         end
         hs1_pkg::CS_ADD: begin
            chain_in = {chain_ff[159:128] + a_ff, chain_ff[127:96] + b_ff,
                        chain_ff[95:64] + c_ff, chain_ff[63:32] + d_ff,
                        chain_ff[31:0] + e_ff};
            state_in = hs1_pkg::CS_IDLE;
         end
         default: state_in = hs1_pkg::CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hs1_pkg::CS_IDLE;
         bits_ff   <= '0;
         chain_ff  <= hs1_pkg::SHA_IV;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bits_ff   <= bits_in;
         chain_ff  <= chain_in;
         rd_vld_ff <= rd_vld_in;
      end
      addr_ff <= addr_in;
      rnd_ff  <= rnd_in;
      wbuf_ff <= wbuf_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
   end

endmodule

// ===== rtl/core/hmac_sha1_engine.sv =====
// ----------------------------------------------------------------------------
// hmac_sha1_engine
// HMAC-SHA1 over byte streams with a stored key and truncated MAC output.
// ----------------------------------------------------------------------------
// req_*: one byte item per transfer. tuser 0 = key byte, 1 = message byte;
//   tdata[8] says the byte in tdata[7:0] is present; tlast ends key or message.
//   A key item after a message abandons the message and loads a new key.
// rsp_*: MAC bytes, most significant first; tlast on the final byte. The
//   count is the csr register (1..20, larger values give 20, 0 gives none).
// csr_*: digest length write; the user must write it only while the block
// is idle, which the block itself does not enforce. Items are taken one at
// a time: a key byte passes through ST_KBYTE and a message byte through
// ST_MSG and ST_MBYTE; each full 64-byte block also runs the hash core
// (buffer read, 80 rounds, chain add) before the next item. A message end
// runs inner padding, the outer key block, the inner digest and outer
// padding before the first MAC byte. The first message item also hashes the
// inner key block. Reset clears all control state and sets the digest
// length to 20 and the key to empty. A stalled receiver holds the output
// register; the block takes the next item while the last MAC byte waits.
// ----------------------------------------------------------------------------
module hmac_sha1_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [8] has_byte, [15:9] zero
   input  logic        req_tuser,   // req_type
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] mac_byte
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   typedef enum logic [14:0] {
      ST_IDLE      = 15'b000000000000001,
      ST_KBYTE     = 15'b000000000000010,
      ST_KEND      = 15'b000000000000100,
      ST_MSG       = 15'b000000000001000,
      ST_MSTART    = 15'b000000000010000,
      ST_KPAD_RD   = 15'b000000000100000,
      ST_KPAD_PUSH = 15'b000000001000000,
      ST_MBYTE     = 15'b000000010000000,
      ST_FINA      = 15'b000000100000000,
      ST_FINZ      = 15'b000001000000000,
      ST_FINL      = 15'b000010000000000,
      ST_FINW      = 15'b000100000000000,
      ST_DIGWR     = 15'b001000000000000,
      ST_IFEED     = 15'b010000000000000,
      ST_EMIT      = 15'b100000000000000
   } state_type;

   typedef enum logic [3:0] {
      PH_AWAIT_KEY = 4'b0001,
      PH_KEY_LOAD  = 4'b0010,
      PH_KEY_READY = 4'b0100,
      PH_MSG_LOAD  = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      RET_KEYDIG = 3'b001,
      RET_INNER  = 3'b010,
      RET_MAC    = 3'b100
   } ret_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   ret_type   ret_ff, ret_in;

   logic [7:0]   key_mem [64];
   logic [7:0]   key_rd_ff;
   logic         key_we, key_re;
   logic [5:0]   key_wa;
   logic [7:0]   key_wd;

   logic         type_ff, type_in, has_ff, has_in, last_ff, last_in;
   logic [7:0]   byte_ff, byte_in;
   logic [6:0]   kcount_ff, kcount_in;
   logic [6:0]   klen_ff, klen_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [7:0]   pad_ff, pad_in;
   logic [63:0]  len_ff, len_in;
   logic [159:0] inner_ff, inner_in;
   logic [4:0]   dlen_ff, dlen_in;
   logic         rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [7:0]   rsp_data_ff, rsp_data_in;

   hs1_pkg::push_type push;
   logic         core_busy, core_ready;
   logic [159:0] chain;
   logic [63:0]  bit_count;
   logic [4:0]   n_out;

   hs1_core u_core (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .busy      (core_busy),
      .chain     (chain),
      .bit_count (bit_count)
   );

   assign core_ready = !core_busy;
   assign n_out      = (dlen_ff > hs1_pkg::MAC_BYTES) ? hs1_pkg::MAC_BYTES : dlen_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= key_wd;
      end
      if (key_re) begin
         key_rd_ff <= key_mem[cnt_ff];
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      ret_in    = ret_ff;
      type_in   = type_ff;
      has_in    = has_ff;
      last_in   = last_ff;
      byte_in   = byte_ff;
      kcount_in = kcount_ff;
      klen_in   = klen_ff;
      cnt_in    = cnt_ff;
      pad_in    = pad_ff;
      len_in    = len_ff;
      inner_in  = inner_ff;
      dlen_in   = csr_valid ? csr_data : dlen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      push       = '0;
      key_we     = 1'b0;
      key_re     = 1'b0;
      key_wa     = kcount_ff[5:0];
      key_wd     = byte_ff;
      req_tready = (state_ff == ST_IDLE) && core_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && core_ready) begin
               type_in = req_tuser;
               byte_in = req_tdata[7:0];
               has_in  = req_tdata[8];
               last_in = req_tlast;
               if (!req_tuser) begin
                  if (phase_ff != PH_KEY_LOAD) begin
                     push.start = 1'b1;
                     kcount_in  = '0;
                     klen_in    = '0;
                     phase_in   = PH_KEY_LOAD;
                  end
                  state_in = ST_KBYTE;
               end else begin
                  state_in = ST_MSG;
               end
            end
         end
         ST_KBYTE: begin
            if (!has_ff || core_ready) begin
               if (has_ff) begin
                  push.valid = 1'b1;
                  push.data  = byte_ff;
                  if (kcount_ff < 7'd64) begin
                     key_we  = 1'b1;
                     klen_in = klen_ff + 7'd1;
                  end
                  if (kcount_ff < 7'd65) begin
                     kcount_in = kcount_ff + 7'd1;
                  end
               end
               state_in = last_ff ? ST_KEND : ST_IDLE;
            end
         end
         ST_KEND: begin
            if (kcount_ff > 7'd64) begin
               ret_in   = RET_KEYDIG;
               state_in = ST_FINA;
            end else begin
               phase_in = PH_KEY_READY;
               state_in = type_ff ? ST_MSTART : ST_IDLE;
            end
         end
         ST_MSG: begin
            if (phase_ff == PH_KEY_LOAD) begin
               state_in = ST_KEND;
            end else if (phase_ff == PH_MSG_LOAD) begin
               state_in = ST_MBYTE;
            end else begin
               state_in = ST_MSTART;
            end
         end
         ST_MSTART: begin
            if (core_ready) begin
               push.start = 1'b1;
               pad_in     = hs1_pkg::IPAD;
               cnt_in     = '0;
               state_in   = ST_KPAD_RD;
            end
         end
         ST_KPAD_RD: begin
            key_re   = 1'b1;
            state_in = ST_KPAD_PUSH;
         end
         ST_KPAD_PUSH: begin
            if (core_ready) begin
               push.valid = 1'b1;
               push.data  = (({1'b0, cnt_ff} < klen_ff) ? key_rd_ff : 8'h00) ^ pad_ff;
               cnt_in     = cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  if (pad_ff == hs1_pkg::IPAD) begin
                     phase_in = PH_MSG_LOAD;
                     state_in = ST_MBYTE;
                  end else begin
                     cnt_in   = '0;
                     state_in = ST_IFEED;
                  end
               end else begin
                  state_in = ST_KPAD_RD;
               end
            end
         end
         ST_MBYTE: begin
            if (!has_ff || core_ready) begin
               push.valid = has_ff;
               push.data  = byte_ff;
               if (last_ff) begin
                  ret_in   = RET_INNER;
                  state_in = ST_FINA;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FINA: begin
            if (core_ready) begin
               push.valid = 1'b1;
               push.data  = hs1_pkg::PAD_LEAD;
               len_in     = bit_count;
               state_in   = ST_FINZ;
            end
         end
         ST_FINZ: begin
            if (bit_count[8:3] == hs1_pkg::LEN_POS) begin
               cnt_in   = '0;
               state_in = ST_FINL;
            end else if (core_ready) begin
               push.valid = 1'b1;
            end
         end
         ST_FINL: begin
            if (core_ready) begin
               push.valid = 1'b1;
               push.data  = len_ff[63:56];
               len_in     = {len_ff[55:0], 8'h00};
               cnt_in     = cnt_ff + 6'd1;
               if (cnt_ff == 6'd7) begin
                  state_in = ST_FINW;
               end
            end
         end
         ST_FINW: begin
            if (core_ready) begin
               cnt_in = '0;
               unique case (ret_ff)
                  RET_KEYDIG: state_in = ST_DIGWR;
                  RET_INNER: begin
                     inner_in   = chain;
                     push.start = 1'b1;
                     pad_in     = hs1_pkg::OPAD;
                     state_in   = ST_KPAD_RD;
                  end
                  RET_MAC: begin
                     phase_in = PH_KEY_READY;
                     state_in = (n_out == 5'd0) ? ST_IDLE : ST_EMIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIGWR: begin
            key_we = 1'b1;
            key_wa = cnt_ff;
            key_wd = hs1_pkg::digest_byte(chain, cnt_ff[4:0]);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd19) begin
               klen_in  = 7'd20;
               phase_in = PH_KEY_READY;
               state_in = type_ff ? ST_MSTART : ST_IDLE;
            end
         end
         ST_IFEED: begin
            if (core_ready) begin
               push.valid = 1'b1;
               push.data  = hs1_pkg::digest_byte(inner_ff, cnt_ff[4:0]);
               cnt_in     = cnt_ff + 6'd1;
               if (cnt_ff == 6'd19) begin
                  ret_in   = RET_MAC;
                  state_in = ST_FINA;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hs1_pkg::digest_byte(chain, cnt_ff[4:0]);
               rsp_last_in  = (cnt_ff[4:0] == n_out - 5'd1);
               cnt_in       = cnt_ff + 6'd1;
               if (cnt_ff[4:0] == n_out - 5'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_AWAIT_KEY;
         ret_ff       <= RET_KEYDIG;
         kcount_ff    <= '0;
         klen_ff      <= '0;
         dlen_ff      <= hs1_pkg::MAC_BYTES;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ret_ff       <= ret_in;
         kcount_ff    <= kcount_in;
         klen_ff      <= klen_in;
         dlen_ff      <= dlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff     <= type_in;
      has_ff      <= has_in;
      last_ff     <= last_in;
      byte_ff     <= byte_in;
      cnt_ff      <= cnt_in;
      pad_ff      <= pad_in;
      len_ff      <= len_in;
      inner_ff    <= inner_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== sim/hmac_sha1_engine_tb.sv =====
// ----------------------------------------------------------------------------
// hmac_sha1_engine_tb
// Self-checking bench: key and message byte streams go in through the request
// stream, an in-bench HMAC-SHA1 predictor works out the MAC bytes, and every
// response transfer is checked against the oldest predicted byte.
// ----------------------------------------------------------------------------
module hmac_sha1_engine_tb;

   localparam bit KEY_ITEM = 1'b0;
   localparam bit MSG_ITEM = 1'b1;

   typedef enum logic [1:0] {
      PH_AWAIT_KEY = 2'd0,
      PH_KEY_LOAD  = 2'd1,
      PH_KEY_READY = 2'd2,
      PH_MSG_LOAD  = 2'd3
   } mac_phase_type;

   typedef struct packed {
      logic [7:0] mac_byte;
      logic       last_res;
   } mac_out_type;

   // HMAC predictor and store of pending MAC bytes
   class hmac_scoreboard;
      logic [4:0]    mac_len;
      logic [31:0]   chain[5];
      logic [7:0]    blk[64];
      logic [7:0]    key_bytes[64];
      int unsigned   key_seen;
      logic [63:0]   bits;
      logic [31:0]   inner[5];
      mac_phase_type phase;
      mac_out_type   pending_mac[$];
      int            errors;

      function void clear();
         mac_len = 5'd20;
         for (int i = 0; i < 5; i++) chain[i] = hs1_pkg::SHA_IV[159 - 32 * i -: 32];
         for (int i = 0; i < 64; i++) begin
            blk[i] = 8'h00;
            key_bytes[i] = 8'h00;
         end
         key_seen = 0;
         bits = 64'd0;
         for (int i = 0; i < 5; i++) inner[i] = 32'd0;
         phase = PH_AWAIT_KEY;
         pending_mac.delete();
         errors = 0;
      endfunction

      function void compress();
         logic [31:0] w[80];
         logic [31:0] a, b, c, d, e, f, k, t;
         for (int i = 0; i < 16; i++)
            w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
         for (int i = 16; i < 80; i++) begin
            t = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
            w[i] = {t[30:0], t[31]};
         end
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
         for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
               f = (b & c) | (~b & d); k = hs1_pkg::K_R0;
            end else if (i < 40) begin
               f = b ^ c ^ d; k = hs1_pkg::K_R1;
            end else if (i < 60) begin
               f = (b & c) | (b & d) | (c & d); k = hs1_pkg::K_R2;
            end else begin
               f = b ^ c ^ d; k = hs1_pkg::K_R3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
      endfunction

      function void restart();
         for (int i = 0; i < 5; i++) chain[i] = hs1_pkg::SHA_IV[159 - 32 * i -: 32];
         bits = 64'd0;
      endfunction

      function void absorb(logic [7:0] v);
         int idx;
         idx = bits[8:3];
         blk[idx] = v;
         bits += 64'd8;
         if (idx == 63) compress();
      endfunction

      function void finish(output logic [31:0] dig[5]);
         logic [63:0] len;
         len = bits;
         absorb(hs1_pkg::PAD_LEAD);
         while (bits[8:3] != hs1_pkg::LEN_POS) absorb(8'h00);
         for (int i = 7; i >= 0; i--) absorb(len[8 * i +: 8]);
         for (int i = 0; i < 5; i++) dig[i] = chain[i];
      endfunction

      function void padded_key(logic [7:0] pad);
         restart();
         for (int i = 0; i < 64; i++) absorb(key_bytes[i] ^ pad);
      endfunction

      function void close_key();
         logic [31:0] dig[5];
         if (key_seen > 64) begin
            finish(dig);
            for (int i = 0; i < 64; i++) key_bytes[i] = 8'h00;
            for (int i = 0; i < 20; i++) key_bytes[i] = dig[i / 4][8 * (3 - i % 4) +: 8];
         end
         phase = PH_KEY_READY;
      endfunction

      function void close_message();
         logic [31:0] mac[5];
         int n;
         finish(inner);
         padded_key(hs1_pkg::OPAD);
         for (int i = 0; i < 20; i++) absorb(inner[i / 4][8 * (3 - i % 4) +: 8]);
         finish(mac);
         phase = PH_KEY_READY;
         n = (mac_len > 5'd20) ? 20 : mac_len;
         for (int i = 0; i < n; i++)
            pending_mac.push_back({mac[i / 4][8 * (3 - i % 4) +: 8], (i + 1 == n)});
      endfunction

      // one accepted request transfer
      function void note_item(bit kind, logic [7:0] v, bit has, bit fin);
         if (kind == KEY_ITEM) begin
            if (phase != PH_KEY_LOAD) begin
               for (int i = 0; i < 64; i++) key_bytes[i] = 8'h00;
               key_seen = 0;
               restart();
               phase = PH_KEY_LOAD;
            end
            if (has) begin
               if (key_seen < 64) key_bytes[key_seen] = v;
               if (key_seen < 65) key_seen++;
               absorb(v);
            end
            if (fin) close_key();
         end else begin
            if (phase == PH_KEY_LOAD) close_key();
            if (phase != PH_MSG_LOAD) begin
               padded_key(hs1_pkg::IPAD);
               phase = PH_MSG_LOAD;
            end
            if (has) absorb(v);
            if (fin) close_message();
         end
      endfunction

      function void check_result(logic [7:0] got_byte, logic got_last);
         mac_out_type exp_r;
         if (pending_mac.size() == 0) begin
            $error("unexpected MAC byte %h", got_byte);
            errors++;
            return;
         end
         exp_r = pending_mac.pop_front();
         if (got_byte !== exp_r.mac_byte) begin
            $error("mac_byte: expected %h, actual %h", exp_r.mac_byte, got_byte);
            errors++;
         end
         if (got_last !== exp_r.last_res) begin
            $error("last_res: expected %b, actual %b", exp_r.last_res, got_last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'd0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data = 5'd0;

   hmac_scoreboard mac_sb = new();
   bit quiet = 1'b0;   // no idling in the final stretch

   hmac_sha1_engine uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #30_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // response side: random stall bursts, check on each transfer
   initial begin
      mac_sb.clear();
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) mac_sb.check_result(rsp_tdata, rsp_tlast);
         if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) begin
               @(posedge clock);
               if (!reset && rsp_tvalid && rsp_tready) mac_sb.check_result(rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // valid stays high bar random gaps; the caller drops it when it stops sending
   task automatic send_item(bit kind, logic [7:0] v, bit has, bit fin);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, has, v};
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      mac_sb.note_item(kind, v, has, fin);
   endtask

   task automatic send_run(bit kind, int len);
      if (len == 0) begin
         send_item(kind, 8'h00, 1'b0, 1'b1);
      end else begin
         for (int i = 0; i < len; i++)
            send_item(kind, $urandom_range(0, 255), 1'b1, i == len - 1);
      end
   endtask

   task automatic drain_and_wait();
      req_tvalid <= 1'b0;
      while (mac_sb.pending_mac.size() != 0) @(posedge clock);
      repeat (1500) @(posedge clock);
   endtask

   task automatic write_len(logic [4:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      mac_sb.mac_len = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      int sent;
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: message without key, then extremes
      send_item(MSG_ITEM, 8'hFF, 1'b1, 1'b0);
      send_item(MSG_ITEM, 8'h00, 1'b0, 1'b0);
      send_item(MSG_ITEM, 8'h00, 1'b1, 1'b1);
      send_run(KEY_ITEM, 0);                    // empty key
      send_run(MSG_ITEM, 0);                    // empty message
      send_item(KEY_ITEM, 8'hAA, 1'b1, 1'b0);
      send_item(KEY_ITEM, 8'h55, 1'b0, 1'b0);
      send_item(KEY_ITEM, 8'h0F, 1'b1, 1'b1);
      send_run(MSG_ITEM, 3);
      send_item(MSG_ITEM, 8'h12, 1'b1, 1'b0);
      send_item(KEY_ITEM, 8'hF0, 1'b1, 1'b1);   // key abandons message
      send_item(MSG_ITEM, 8'h34, 1'b1, 1'b1);
      drain_and_wait();
      write_len(5'd1);
      send_run(MSG_ITEM, 2);
      drain_and_wait();
      write_len(5'd0);
      send_run(MSG_ITEM, 1);
      drain_and_wait();
      write_len(5'd31);
      send_run(KEY_ITEM, 70);                   // long key gets hashed
      send_run(MSG_ITEM, 1);
      sent = 88;

      while (sent < 262) begin
         if (sent > 210) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0: begin
               drain_and_wait();
               write_len($urandom_range(0, 31));
            end
            1: begin
               n = $urandom_range(0, 80);
               send_run(KEY_ITEM, n);
               sent += (n == 0) ? 1 : n;
            end
            2: begin
               send_item($urandom_range(0, 1), $urandom_range(0, 255),
                         $urandom_range(0, 1), $urandom_range(0, 1));
               sent++;
            end
            default: begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
               send_run(MSG_ITEM, n);
               sent += (n == 0) ? 1 : n;
            end
         endcase
      end
      send_run(MSG_ITEM, 2);
      drain_and_wait();
      write_len(5'd20);
      send_run(MSG_ITEM, 1);
      req_tvalid <= 1'b0;

      fork
         while (mac_sb.pending_mac.size() != 0) @(posedge clock);
         repeat (200_000) @(posedge clock);
      join_any
      disable fork;
      repeat (800) @(posedge clock);
      if (mac_sb.pending_mac.size() == 0 && mac_sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         if (mac_sb.pending_mac.size() != 0)
            $error("%0d MAC bytes never arrived", mac_sb.pending_mac.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
